// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define DPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define DPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/dpgpc_pkg.sv =====
// Shared types, widths and constants of the depth pixel ground plane classifier.
package dpgpc_pkg;

    // Field and arithmetic widths
    localparam int DEPTH_W         = 16;
    localparam int COORD_W         = 12;
    localparam int COORD_BITS      = 12;
    localparam int CENTRE_W        = 16;
    localparam int OFF_W           = 16;
    localparam int RECIP_FRAC_BITS = 24;
    localparam int MAG1_W          = OFF_W + DEPTH_W;
    localparam int MAG2_W          = MAG1_W + RECIP_FRAC_BITS;
    localparam int RND_SHIFT       = RECIP_FRAC_BITS + 4;
    localparam int RQ_W            = MAG2_W + 1 - RND_SHIFT;
    localparam int PT_W            = 16;
    localparam int NORM_W          = 16;
    localparam int NORM_FRAC       = 15;
    localparam int THR_W           = 12;
    localparam int PA_W            = NORM_W + DEPTH_W + 1;
    localparam int PB_W            = NORM_W + PT_W;
    localparam int SUM_W           = PA_W + 2;
    localparam int NLANE           = 2;

    // Stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // Pipeline stage indexes
    localparam int ST_GATE  = 0;
    localparam int ST_MUL1  = 1;
    localparam int ST_MUL2  = 2;
    localparam int ST_ROUND = 3;
    localparam int ST_PMUL  = 4;
    localparam int ST_SUM   = 5;
    localparam int ST_CMP   = 6;
    localparam int NSTAGE   = 7;

    // Register file layout
    localparam int ADDR_W    = 6;
    localparam int IDX_LSB   = 3;
    localparam int IDX_W     = ADDR_W - IDX_LSB;
    localparam int APB_DW    = 64;
    localparam logic [IDX_W-1:0] REG_DEPTH_RANGE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRINCIPAL    = 3'd1;
    localparam logic [IDX_W-1:0] REG_INV_FOCAL    = 3'd2;
    localparam logic [IDX_W-1:0] REG_PLANE_NORMAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLANE_OFFSET = 3'd4;
    localparam logic [IDX_W-1:0] REG_PLANE_THR    = 3'd5;

    // Register reset values
    localparam logic [31:0]      RST_DEPTH_RANGE  = 32'h1388_00C8;
    localparam logic [31:0]      RST_PRINCIPAL    = 32'h0F00_1400;
    localparam logic [47:0]      RST_INV_FOCAL    = 48'h006D_3A00_6D3A;
    localparam logic [47:0]      RST_PLANE_NORMAL = 48'h7FFF_0000_0000;
    localparam logic [15:0]      RST_PLANE_OFFSET = 16'h0000;
    localparam logic [THR_W-1:0] RST_PLANE_THR    = 12'd30;

    // Stage enables and valid bits from the pipeline control
    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } t_pipe_ctl;

    // Decoded configuration
    typedef struct packed {
        logic [DEPTH_W-1:0]         depth_min;
        logic [DEPTH_W-1:0]         depth_max;
        logic [CENTRE_W-1:0]        cx;
        logic [CENTRE_W-1:0]        cy;
        logic [RECIP_FRAC_BITS-1:0] recip_x;
        logic [RECIP_FRAC_BITS-1:0] recip_y;
        logic [NORM_W-1:0]          norm_a;
        logic [NORM_W-1:0]          norm_b;
        logic [NORM_W-1:0]          norm_c;
        logic [NORM_W-1:0]          offset;
        logic [THR_W-1:0]           thr;
    } t_cfg;

    // Camera-frame point after back-projection
    typedef struct packed {
        logic              valid;
        logic [DEPTH_W-1:0] fwd;
        logic [PT_W-1:0]    left;
        logic [PT_W-1:0]    up;
    } t_point;

    // Final result
    typedef struct packed {
        logic               valid;
        logic               trav;
        logic [DEPTH_W-1:0] fwd;
        logic [PT_W-1:0]    left;
        logic [PT_W-1:0]    up;
    } t_result;

endpackage

// ===== rtl/core/depth_pixel_ground_plane_classifier.sv =====
// Pipeline: seven register stages, from the range gate to the plane compare; results leave the last one.
// Throughput: one pixel per cycle unless output back-pressure fills the stages; the seven register stages each advance
// on their own, so bubbles close up while a result waits on the output.
// Reset: synchronous active-low; clears all stage valid bits and loads the
// configuration defaults (200..5000 mm, centre 320/240, f about 600, plane z up).
// Top level of the depth pixel ground plane classifier.
module depth_pixel_ground_plane_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // depth_mm [15:0], column [27:16], row [39:28]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [dpgpc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // forward_mm [15:0], left_mm [31:16], up_mm [47:32]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [dpgpc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // valid_res [0], traversable [1]
    output logic [dpgpc_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dpgpc_pkg::ADDR_W-1:0]         paddr,
    input  logic [dpgpc_pkg::APB_DW-1:0]         pwdata,
    output logic [dpgpc_pkg::APB_DW-1:0]         prdata,
    output logic                                 pready
);

    dpgpc_pkg::t_cfg      cfg;
    dpgpc_pkg::t_pipe_ctl ctl;
    dpgpc_pkg::t_point    point;
    dpgpc_pkg::t_result   result;

    dpgpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dpgpc_pipe_ctrl u_pipe_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (ctl)
    );

    dpgpc_backproject u_backproject (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .i_depth  (s_axis_tdata[15:0]),
        .i_column (s_axis_tdata[27:16]),
        .i_row    (s_axis_tdata[39:28]),
        .o_point  (point)
    );

    dpgpc_plane_test u_plane_test (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .i_point  (point),
        .o_result (result)
    );

    // Drive the output stream from the last stage
    assign s_axis_tready = ctl.en[dpgpc_pkg::ST_GATE];
    assign m_axis_tvalid = ctl.vld[dpgpc_pkg::ST_CMP];
    assign m_axis_tdata  = {result.up, result.left, result.fwd};
    assign m_axis_tuser  = {result.trav, result.valid};

endmodule

// ===== rtl/core/dpgpc_cfg_regs.sv =====
// APB register file holding range, intrinsics and plane configuration.
module dpgpc_cfg_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dpgpc_pkg::ADDR_W-1:0]           paddr,
    input  logic [dpgpc_pkg::APB_DW-1:0]           pwdata,
    output logic [dpgpc_pkg::APB_DW-1:0]           prdata,
    output logic                                   pready,
    output dpgpc_pkg::t_cfg                        o_cfg
);

    logic [31:0]                   r_depth_range;
    logic [31:0]                   r_principal;
    logic [47:0]                   r_inv_focal;
    logic [47:0]                   r_plane_normal;
    logic [15:0]                   r_plane_offset;
    logic [dpgpc_pkg::THR_W-1:0]   r_plane_thr;
    logic [dpgpc_pkg::IDX_W-1:0]   idx;
    logic                          wr_req;

    assign idx    = paddr[dpgpc_pkg::ADDR_W-1:dpgpc_pkg::IDX_LSB];
    assign wr_req = psel & penable & pwrite;
    assign pready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_range  <= dpgpc_pkg::RST_DEPTH_RANGE;
            r_principal    <= dpgpc_pkg::RST_PRINCIPAL;
            r_inv_focal    <= dpgpc_pkg::RST_INV_FOCAL;
            r_plane_normal <= dpgpc_pkg::RST_PLANE_NORMAL;
            r_plane_offset <= dpgpc_pkg::RST_PLANE_OFFSET;
            r_plane_thr    <= dpgpc_pkg::RST_PLANE_THR;
        end else if (wr_req) begin
            case (idx)
                dpgpc_pkg::REG_DEPTH_RANGE:  r_depth_range  <= pwdata[31:0];
                dpgpc_pkg::REG_PRINCIPAL:    r_principal    <= pwdata[31:0];
                dpgpc_pkg::REG_INV_FOCAL:    r_inv_focal    <= pwdata[47:0];
                dpgpc_pkg::REG_PLANE_NORMAL: r_plane_normal <= pwdata[47:0];
                dpgpc_pkg::REG_PLANE_OFFSET: r_plane_offset <= pwdata[15:0];
                dpgpc_pkg::REG_PLANE_THR:    r_plane_thr    <= pwdata[dpgpc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (idx)
            dpgpc_pkg::REG_DEPTH_RANGE:  prdata = dpgpc_pkg::APB_DW'(r_depth_range);
            dpgpc_pkg::REG_PRINCIPAL:    prdata = dpgpc_pkg::APB_DW'(r_principal);
            dpgpc_pkg::REG_INV_FOCAL:    prdata = dpgpc_pkg::APB_DW'(r_inv_focal);
            dpgpc_pkg::REG_PLANE_NORMAL: prdata = dpgpc_pkg::APB_DW'(r_plane_normal);
            dpgpc_pkg::REG_PLANE_OFFSET: prdata = dpgpc_pkg::APB_DW'(r_plane_offset);
            dpgpc_pkg::REG_PLANE_THR:    prdata = dpgpc_pkg::APB_DW'(r_plane_thr);
            default:                     prdata = '0;
        endcase
    end

    // Split registers into fields
    assign o_cfg.depth_min = r_depth_range[15:0];
    assign o_cfg.depth_max = r_depth_range[31:16];
    assign o_cfg.cx        = r_principal[15:0];
    assign o_cfg.cy        = r_principal[31:16];
    assign o_cfg.recip_x   = r_inv_focal[23:0];
    assign o_cfg.recip_y   = r_inv_focal[47:24];
    assign o_cfg.norm_a    = r_plane_normal[15:0];
    assign o_cfg.norm_b    = r_plane_normal[31:16];
    assign o_cfg.norm_c    = r_plane_normal[47:32];
    assign o_cfg.offset    = r_plane_offset;
    assign o_cfg.thr       = r_plane_thr;

endmodule

// ===== rtl/core/dpgpc_pipe_ctrl.sv =====
// Valid bits and per-stage enables of the classifier pipeline.
`include "assert_macros.svh"

module dpgpc_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output dpgpc_pkg::t_pipe_ctl o_ctl
);

    logic [dpgpc_pkg::NSTAGE-1:0] r_vld;
    logic [dpgpc_pkg::NSTAGE-1:0] n_vld;
    logic [dpgpc_pkg::NSTAGE-1:0] rdy;

    // A stage loads when it is empty or its successor moves on
    always_comb begin
        rdy[dpgpc_pkg::NSTAGE-1] = !r_vld[dpgpc_pkg::NSTAGE-1] || i_out_ready;
        for (int k = dpgpc_pkg::NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    // Advance valid bits, collapse bubbles
    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < dpgpc_pkg::NSTAGE; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en  = rdy;
    assign o_ctl.vld = r_vld;

    `DPG_ASSERT_NXT(a_take_request, i_clk, i_rst_n, i_in_valid && rdy[0], r_vld[0],
        "accepted request did not enter the first stage")
    `DPG_ASSERT_IMP(a_empty_out_flows, i_clk, i_rst_n, !r_vld[dpgpc_pkg::NSTAGE-1], &rdy,
        "pipeline stalled with an empty output stage")
    `DPG_ASSERT_NXT(a_stall_keeps, i_clk, i_rst_n, r_vld[0] && !rdy[0], r_vld[0],
        "stalled first stage lost its request")

endmodule

// ===== rtl/core/dpgpc_backproject.sv =====
// Range gate and pinhole back-projection of a depth pixel, four stages.
module dpgpc_backproject (
    input  logic                                 i_clk,
    input  dpgpc_pkg::t_pipe_ctl                 i_ctl,
    input  dpgpc_pkg::t_cfg                      i_cfg,
    input  logic [dpgpc_pkg::DEPTH_W-1:0]        i_depth,
    input  logic [dpgpc_pkg::COORD_W-1:0]        i_column,
    input  logic [dpgpc_pkg::COORD_W-1:0]        i_row,
    output dpgpc_pkg::t_point                    o_point
);

    localparam int NL = dpgpc_pkg::NLANE;
    localparam logic [dpgpc_pkg::MAG2_W:0] RND_HALF =
        (dpgpc_pkg::MAG2_W + 1)'(1) << (dpgpc_pkg::RND_SHIFT - 1);

    logic [dpgpc_pkg::COORD_BITS-1:0]      coord    [NL];
    logic [dpgpc_pkg::CENTRE_W-1:0]        centre   [NL];
    logic [dpgpc_pkg::RECIP_FRAC_BITS-1:0] recip    [NL];
    logic signed [dpgpc_pkg::OFF_W:0]      off_s    [NL];
    logic [dpgpc_pkg::OFF_W:0]             off_abs  [NL];
    logic [dpgpc_pkg::MAG2_W:0]            rnd      [NL];
    logic [dpgpc_pkg::RQ_W-1:0]            rq       [NL];
    logic [dpgpc_pkg::PT_W-1:0]            sat      [NL];
    logic                                  n_valid;

    logic                                  r0_valid;
    logic [dpgpc_pkg::DEPTH_W-1:0]         r0_depth;
    logic [dpgpc_pkg::OFF_W-1:0]           r0_off   [NL];
    logic                                  r0_neg   [NL];
    logic                                  r1_valid;
    logic [dpgpc_pkg::DEPTH_W-1:0]         r1_depth;
    logic [dpgpc_pkg::MAG1_W-1:0]          r1_mag   [NL];
    logic                                  r1_neg   [NL];
    logic                                  r2_valid;
    logic [dpgpc_pkg::DEPTH_W-1:0]         r2_depth;
    logic [dpgpc_pkg::MAG2_W-1:0]          r2_prod  [NL];
    logic                                  r2_neg   [NL];
    dpgpc_pkg::t_point                     r3_point;

    // Lane 0 projects the column, lane 1 the row
    assign coord[0]  = i_column[dpgpc_pkg::COORD_BITS-1:0];
    assign coord[1]  = i_row[dpgpc_pkg::COORD_BITS-1:0];
    assign centre[0] = i_cfg.cx;
    assign centre[1] = i_cfg.cy;
    assign recip[0]  = i_cfg.recip_x;
    assign recip[1]  = i_cfg.recip_y;

    // Gate the depth against the range, form offset magnitude and sign
    assign n_valid = (i_depth != '0) && (i_depth >= i_cfg.depth_min) &&
                     (i_depth <= i_cfg.depth_max);

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            off_s[l]   = $signed((dpgpc_pkg::OFF_W + 1)'({coord[l], 4'b0000})) -
                         $signed({1'b0, centre[l]});
            off_abs[l] = off_s[l][dpgpc_pkg::OFF_W] ? (dpgpc_pkg::OFF_W + 1)'(-off_s[l])
                                                    : (dpgpc_pkg::OFF_W + 1)'(off_s[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_GATE]) begin
            r0_valid <= n_valid;
            r0_depth <= i_depth;
            for (int l = 0; l < NL; l++) begin
                r0_off[l] <= off_abs[l][dpgpc_pkg::OFF_W-1:0];
                r0_neg[l] <= off_s[l][dpgpc_pkg::OFF_W];
            end
        end
    end

    // Scale the offset by the depth
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_MUL1]) begin
            r1_valid <= r0_valid;
            r1_depth <= r0_depth;
            for (int l = 0; l < NL; l++) begin
                r1_mag[l] <= r0_off[l] * r0_depth;
                r1_neg[l] <= r0_neg[l];
            end
        end
    end

    // Scale by the reciprocal focal length
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_MUL2]) begin
            r2_valid <= r1_valid;
            r2_depth <= r1_depth;
            for (int l = 0; l < NL; l++) begin
                r2_prod[l] <= r1_mag[l] * recip[l];
                r2_neg[l]  <= r1_neg[l];
            end
        end
    end

    // Round half away from zero, negate and saturate to 16 bits
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            rnd[l] = {1'b0, r2_prod[l]} + RND_HALF;
            rq[l]  = rnd[l][dpgpc_pkg::MAG2_W:dpgpc_pkg::RND_SHIFT];
            if (r2_neg[l]) begin
                sat[l] = (rq[l] > dpgpc_pkg::RQ_W'(32767)) ? 16'h7FFF
                                                            : rq[l][dpgpc_pkg::PT_W-1:0];
            end else begin
                sat[l] = (rq[l] > dpgpc_pkg::RQ_W'(32768)) ? 16'h8000
                                                            : -rq[l][dpgpc_pkg::PT_W-1:0];
            end
        end
    end

    // Zero every field of an invalid pixel
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_ROUND]) begin
            r3_point.valid <= r2_valid;
            r3_point.fwd   <= r2_valid ? r2_depth : '0;
            r3_point.left  <= r2_valid ? sat[0] : '0;
            r3_point.up    <= r2_valid ? sat[1] : '0;
        end
    end

    assign o_point = r3_point;

endmodule

// ===== rtl/core/dpgpc_plane_test.sv =====
// Plane distance test of a camera-frame point, three stages.
module dpgpc_plane_test (
    input  logic                  i_clk,
    input  dpgpc_pkg::t_pipe_ctl  i_ctl,
    input  dpgpc_pkg::t_cfg       i_cfg,
    input  dpgpc_pkg::t_point     i_point,
    output dpgpc_pkg::t_result    o_result
);

    logic signed [dpgpc_pkg::PA_W-1:0]  r4_pa;
    logic signed [dpgpc_pkg::PB_W-1:0]  r4_pb;
    logic signed [dpgpc_pkg::PB_W-1:0]  r4_pc;
    dpgpc_pkg::t_point                  r4_point;
    logic signed [dpgpc_pkg::SUM_W-1:0] r5_sum;
    dpgpc_pkg::t_point                  r5_point;
    dpgpc_pkg::t_result                 r6_result;
    logic [dpgpc_pkg::SUM_W-1:0]        dist_mag;
    logic [dpgpc_pkg::SUM_W-1:0]        lim;

    // Multiply each coordinate by its normal component
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_PMUL]) begin
            r4_point <= i_point;
            r4_pa    <= $signed(i_cfg.norm_a) * $signed({1'b0, i_point.fwd});
            r4_pb    <= $signed(i_cfg.norm_b) * $signed(i_point.left);
            r4_pc    <= $signed(i_cfg.norm_c) * $signed(i_point.up);
        end
    end

    // Add the products and the offset in Q.15
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_SUM]) begin
            r5_point <= r4_point;
            r5_sum   <= dpgpc_pkg::SUM_W'(r4_pa) + dpgpc_pkg::SUM_W'(r4_pb) +
                        dpgpc_pkg::SUM_W'(r4_pc) +
                        (dpgpc_pkg::SUM_W'($signed(i_cfg.offset)) <<< dpgpc_pkg::NORM_FRAC);
        end
    end

    // Compare the distance against twice the threshold
    assign dist_mag = r5_sum[dpgpc_pkg::SUM_W-1] ? dpgpc_pkg::SUM_W'(-r5_sum)
                                                 : dpgpc_pkg::SUM_W'(r5_sum);
    assign lim      = dpgpc_pkg::SUM_W'({i_cfg.thr, (dpgpc_pkg::NORM_FRAC + 1)'(0)});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[dpgpc_pkg::ST_CMP]) begin
            r6_result.valid <= r5_point.valid;
            r6_result.trav  <= r5_point.valid && (dist_mag < lim);
            r6_result.fwd   <= r5_point.fwd;
            r6_result.left  <= r5_point.left;
            r6_result.up    <= r5_point.up;
        end
    end

    assign o_result = r6_result;

endmodule

// ===== dv/tb_depth_pixel_ground_plane_classifier.sv =====
// Self-checking testbench for the depth pixel ground plane classifier.
module tb_depth_pixel_ground_plane_classifier;

    // Register slots past the map; writes to them must change nothing
    localparam logic [dpgpc_pkg::IDX_W-1:0] REG_HOLE_LO   = 3'd6;
    localparam logic [dpgpc_pkg::IDX_W-1:0] REG_HOLE_HI   = 3'd7;
    localparam int                          BACKLOG_CYCLES = 150;
    localparam int                          SETTLE_CYCLES  = 2 * dpgpc_pkg::NSTAGE + 6;

    typedef struct packed {
        logic [dpgpc_pkg::DEPTH_W-1:0] depth;
        logic [dpgpc_pkg::COORD_W-1:0] col;
        logic [dpgpc_pkg::COORD_W-1:0] row;
        logic                          typed;
        dpgpc_pkg::t_result            res;
    } t_pixel_vec;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dpgpc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dpgpc_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [dpgpc_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [dpgpc_pkg::ADDR_W-1:0]    paddr = '0;
    logic [dpgpc_pkg::APB_DW-1:0]    pwdata = '0;
    logic [dpgpc_pkg::APB_DW-1:0]    prdata;
    logic                            pready;

    // Configuration as the block should hold it
    dpgpc_pkg::t_cfg    cfg_now;
    dpgpc_pkg::t_result pending_results[$];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit want_backlog = 1'b0;

    int n_fail = 0;
    int n_pixels = 0;
    int n_results = 0;
    int n_valid = 0;
    int n_trav = 0;
    int n_sat = 0;
    int n_settings = 0;
    int n_in_stall = 0;

    // Directed pixels under the reset configuration (200..5000 mm, centre 320/240)
    t_pixel_vec directed_rows [15] = '{
        '{16'd0,     12'd320,  12'd240,  1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
        '{16'd199,   12'd320,  12'd240,  1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
        '{16'd5001,  12'd320,  12'd240,  1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
        '{16'd65535, 12'd4095, 12'd4095, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
        '{16'd200,   12'd320,  12'd240,  1'b1, '{1'b1, 1'b1, 16'd200, 16'd0, 16'd0}},
        '{16'd5000,  12'd320,  12'd240,  1'b1, '{1'b1, 1'b1, 16'd5000, 16'd0, 16'd0}},
        '{16'd5000,  12'd0,    12'd0,    1'b0, '0},
        '{16'd5000,  12'd4095, 12'd4095, 1'b0, '0},
        '{16'd1000,  12'd0,    12'd4095, 1'b0, '0},
        '{16'd1000,  12'd4095, 12'd0,    1'b0, '0},
        '{16'd1000,  12'd100,  12'd240,  1'b0, '0},
        '{16'd4369,  12'hAAA,  12'h555,  1'b0, '0},
        '{16'd2730,  12'h555,  12'hAAA,  1'b0, '0},
        '{16'd201,   12'd321,  12'd241,  1'b0, '0},
        '{16'd4999,  12'd319,  12'd239,  1'b0, '0}
    };

    depth_pixel_ground_plane_classifier u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // Back-project one image axis to mm: round half away from zero, negate, saturate
    function automatic longint backproject(logic [dpgpc_pkg::COORD_W-1:0] pix,
                                           logic [dpgpc_pkg::CENTRE_W-1:0] centre,
                                           logic [dpgpc_pkg::DEPTH_W-1:0] depth,
                                           logic [dpgpc_pkg::RECIP_FRAC_BITS-1:0] recip);
        longint off;
        longint prod;
        longint mag;
        longint mm;
        off  = longint'(pix) * 16 - longint'(centre);
        prod = off * longint'(depth) * longint'(recip);
        mag  = (prod < 0) ? -prod : prod;
        mm   = (mag + (longint'(1) << (dpgpc_pkg::RND_SHIFT - 1))) >>> dpgpc_pkg::RND_SHIFT;
        if (mm > 40000) mm = 40000;
        mm = (prod < 0) ? mm : -mm;
        if (mm > 32767) mm = 32767;
        if (mm < -32768) mm = -32768;
        return mm;
    endfunction

    // Gate on depth range, back-project and test distance to the ground plane
    function automatic dpgpc_pkg::t_result classify_pixel(
        logic [dpgpc_pkg::DEPTH_W-1:0] depth,
        logic [dpgpc_pkg::COORD_W-1:0] col,
        logic [dpgpc_pkg::COORD_W-1:0] row);
        dpgpc_pkg::t_result res;
        longint  lft;
        longint  upv;
        longint  sum;
        longint  mag;
        longint  lim;
        res = '0;
        if (depth == '0 || depth < cfg_now.depth_min || depth > cfg_now.depth_max) return res;
        lft = backproject(col, cfg_now.cx, depth, cfg_now.recip_x);
        upv = backproject(row, cfg_now.cy, depth, cfg_now.recip_y);
        sum = longint'($signed(cfg_now.norm_a)) * longint'(depth)
            + longint'($signed(cfg_now.norm_b)) * lft
            + longint'($signed(cfg_now.norm_c)) * upv
            + longint'($signed(cfg_now.offset)) * 32768;
        mag = (sum < 0) ? -sum : sum;
        lim = longint'(cfg_now.thr) * 65536;
        res.valid = 1'b1;
        res.trav  = (mag < lim);
        res.fwd   = depth;
        res.left  = lft[dpgpc_pkg::PT_W-1:0];
        res.up    = upv[dpgpc_pkg::PT_W-1:0];
        return res;
    endfunction

    // Register word as a read should return it
    function automatic logic [dpgpc_pkg::APB_DW-1:0] cfg_word(
        logic [dpgpc_pkg::IDX_W-1:0] idx);
        case (idx)
            dpgpc_pkg::REG_DEPTH_RANGE:
                return {32'd0, cfg_now.depth_max, cfg_now.depth_min};
            dpgpc_pkg::REG_PRINCIPAL:
                return {32'd0, cfg_now.cy, cfg_now.cx};
            dpgpc_pkg::REG_INV_FOCAL:
                return {16'd0, cfg_now.recip_y, cfg_now.recip_x};
            dpgpc_pkg::REG_PLANE_NORMAL:
                return {16'd0, cfg_now.norm_c, cfg_now.norm_b, cfg_now.norm_a};
            dpgpc_pkg::REG_PLANE_OFFSET:
                return {48'd0, cfg_now.offset};
            dpgpc_pkg::REG_PLANE_THR:
                return {52'd0, cfg_now.thr};
            default:
                return '0;
        endcase
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // Read a register back and compare with the held configuration
    task automatic verify_register(logic [dpgpc_pkg::IDX_W-1:0] idx);
        logic [dpgpc_pkg::APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= dpgpc_pkg::ADDR_W'(idx) << dpgpc_pkg::IDX_LSB;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== cfg_word(idx)) begin
            $error("register %0d readback mismatch: expected %h, got %h", idx, cfg_word(idx), rd);
            n_fail++;
        end
    endtask

    // Write one register over APB and mirror it
    task automatic cfg_write(logic [dpgpc_pkg::IDX_W-1:0] idx,
                             logic [dpgpc_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dpgpc_pkg::ADDR_W'(idx) << dpgpc_pkg::IDX_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dpgpc_pkg::REG_DEPTH_RANGE: begin
                cfg_now.depth_min = value[15:0];
                cfg_now.depth_max = value[31:16];
            end
            dpgpc_pkg::REG_PRINCIPAL: begin
                cfg_now.cx = value[15:0];
                cfg_now.cy = value[31:16];
            end
            dpgpc_pkg::REG_INV_FOCAL: begin
                cfg_now.recip_x = value[23:0];
                cfg_now.recip_y = value[47:24];
            end
            dpgpc_pkg::REG_PLANE_NORMAL: begin
                cfg_now.norm_a = value[15:0];
                cfg_now.norm_b = value[31:16];
                cfg_now.norm_c = value[47:32];
            end
            dpgpc_pkg::REG_PLANE_OFFSET: cfg_now.offset = value[15:0];
            dpgpc_pkg::REG_PLANE_THR:    cfg_now.thr = value[dpgpc_pkg::THR_W-1:0];
            default: ;
        endcase
        if (idx != REG_HOLE_LO && idx != REG_HOLE_HI) verify_register(idx);
    endtask

    task automatic load_setting(logic [31:0] range, logic [31:0] centre, logic [47:0] focal,
                                logic [47:0] normal, logic [15:0] offset,
                                logic [dpgpc_pkg::THR_W-1:0] thr);
        cfg_write(dpgpc_pkg::REG_DEPTH_RANGE, {32'd0, range});
        cfg_write(dpgpc_pkg::REG_PRINCIPAL, {32'd0, centre});
        cfg_write(dpgpc_pkg::REG_INV_FOCAL, {16'd0, focal});
        cfg_write(dpgpc_pkg::REG_PLANE_NORMAL, {16'd0, normal});
        cfg_write(dpgpc_pkg::REG_PLANE_OFFSET, {48'd0, offset});
        cfg_write(dpgpc_pkg::REG_PLANE_THR, {52'd0, thr});
        n_settings++;
    endtask

    // Offer one pixel request; queue its expected result when accepted
    task automatic send_pixel(logic [dpgpc_pkg::DEPTH_W-1:0] depth,
                              logic [dpgpc_pkg::COORD_W-1:0] col,
                              logic [dpgpc_pkg::COORD_W-1:0] row, logic typed,
                              dpgpc_pkg::t_result res);
        int                 gap;
        dpgpc_pkg::t_result expected;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col, depth};
        do begin
            @(posedge i_clk);
            if (s_axis_tvalid && !s_axis_tready) n_in_stall++;
        end while (!(s_axis_tvalid && s_axis_tready));
        expected = typed ? res : classify_pixel(depth, col, row);
        pending_results.insert(pending_results.size(), expected);
        n_pixels++;
        gap = tx_steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        logic [dpgpc_pkg::DEPTH_W-1:0] depth;
        logic [dpgpc_pkg::COORD_W-1:0] col;
        logic [dpgpc_pkg::COORD_W-1:0] row;
        int                            r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                depth = '0;
            else if (r < 14)
                depth = dpgpc_pkg::DEPTH_W'($urandom);
            else if (r < 20)
                case ($urandom_range(0, 3))
                    0: depth = cfg_now.depth_min;
                    1: depth = cfg_now.depth_max;
                    2: depth = cfg_now.depth_min - 1'b1;
                    default: depth = cfg_now.depth_max + 1'b1;
                endcase
            else if (cfg_now.depth_min <= cfg_now.depth_max)
                depth = dpgpc_pkg::DEPTH_W'($urandom_range(cfg_now.depth_min,
                                                           cfg_now.depth_max));
            else
                depth = dpgpc_pkg::DEPTH_W'($urandom);
            col = ($urandom_range(0, 9) == 0) ? {dpgpc_pkg::COORD_W{r[0]}}
                                              : dpgpc_pkg::COORD_W'($urandom);
            row = ($urandom_range(0, 9) == 0) ? {dpgpc_pkg::COORD_W{r[1]}}
                                              : dpgpc_pkg::COORD_W'($urandom);
            send_pixel(depth, col, row, 1'b0, '0);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic run_phase(int count);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        send_random(count);
        drain_results();
    endtask

    // Plausible camera and a plane close to the image horizon
    task automatic load_ground_setting();
        logic [15:0] dmin, dmax, cx, cy, a, b, c, d;
        logic [23:0] fx, fy;
        int          t;
        dmin = 16'($urandom_range(0, 800));
        dmax = 16'($urandom_range(2000, 65535));
        cx   = 16'($urandom_range(1600, 16000));
        cy   = 16'($urandom_range(1600, 16000));
        fx   = 24'($urandom_range(10000, 80000));
        fy   = 24'($urandom_range(10000, 80000));
        t = $urandom_range(0, 6000) - 3000;
        a = t[15:0];
        t = $urandom_range(0, 6000) - 3000;
        b = t[15:0];
        c = 16'($urandom_range(20000, 32767));
        t = $urandom_range(0, 4000) - 2000;
        d = t[15:0];
        load_setting({dmax, dmin}, {cy, cx}, {fy, fx}, {c, b, a}, d,
                     dpgpc_pkg::THR_W'($urandom_range(10, 3000)));
    endtask

    task automatic load_wild_setting();
        load_setting($urandom, $urandom, {16'($urandom), 32'($urandom)},
                     {16'($urandom), 32'($urandom)}, 16'($urandom),
                     dpgpc_pkg::THR_W'($urandom));
    endtask

    // Receiver: random ready with short and long stalls, one long hold on request
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (want_backlog) begin
                m_axis_tready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge i_clk);
                want_backlog = 1'b0;
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            stall = rx_steady ? 0 : idle_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        dpgpc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no pending request: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                check_field("valid_res", want.valid, m_axis_tuser[0]);
                check_field("traversable", want.trav, m_axis_tuser[1]);
                check_field("forward_mm", want.fwd, m_axis_tdata[15:0]);
                check_field("left_mm", $signed(want.left), $signed(m_axis_tdata[31:16]));
                check_field("up_mm", $signed(want.up), $signed(m_axis_tdata[47:32]));
                if (want.valid) n_valid++;
                if (want.trav) n_trav++;
                if (want.valid && (want.left == 16'h7FFF || want.left == 16'h8000 ||
                                   want.up == 16'h7FFF || want.up == 16'h8000))
                    n_sat++;
            end
        end
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        cfg_now.depth_min = dpgpc_pkg::RST_DEPTH_RANGE[15:0];
        cfg_now.depth_max = dpgpc_pkg::RST_DEPTH_RANGE[31:16];
        cfg_now.cx        = dpgpc_pkg::RST_PRINCIPAL[15:0];
        cfg_now.cy        = dpgpc_pkg::RST_PRINCIPAL[31:16];
        cfg_now.recip_x   = dpgpc_pkg::RST_INV_FOCAL[23:0];
        cfg_now.recip_y   = dpgpc_pkg::RST_INV_FOCAL[47:24];
        cfg_now.norm_a    = dpgpc_pkg::RST_PLANE_NORMAL[15:0];
        cfg_now.norm_b    = dpgpc_pkg::RST_PLANE_NORMAL[31:16];
        cfg_now.norm_c    = dpgpc_pkg::RST_PLANE_NORMAL[47:32];
        cfg_now.offset    = dpgpc_pkg::RST_PLANE_OFFSET;
        cfg_now.thr       = dpgpc_pkg::RST_PLANE_THR;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values read back
        verify_register(dpgpc_pkg::REG_DEPTH_RANGE);
        verify_register(dpgpc_pkg::REG_PRINCIPAL);
        verify_register(dpgpc_pkg::REG_INV_FOCAL);
        verify_register(dpgpc_pkg::REG_PLANE_NORMAL);
        verify_register(dpgpc_pkg::REG_PLANE_OFFSET);
        verify_register(dpgpc_pkg::REG_PLANE_THR);

        // Directed pixels, then random ones under the reset configuration
        foreach (directed_rows[k])
            send_pixel(directed_rows[k].depth, directed_rows[k].col, directed_rows[k].row,
                       directed_rows[k].typed, directed_rows[k].res);
        send_random(150);
        drain_results();

        // Full depth range, largest reciprocals, far corner centre: coordinates saturate
        load_setting(32'hFFFF_0000, 32'hFFFF_0000, 48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF,
                     16'h7FFF, 12'hFFF);
        run_phase(150);

        // Minimum above maximum: nothing is valid
        load_setting(32'h00C8_1388, 32'h0F00_1400, 48'h006D_3A00_6D3A, 48'h7FFF_0000_0000,
                     16'h0000, 12'd30);
        run_phase(50);

        // Zero reciprocals, most negative normal and offset, zero threshold
        load_setting(32'hFFFF_0001, 32'h0000_FFFF, 48'h0, 48'h8000_8000_8000, 16'h8000, 12'd0);
        run_phase(100);

        // Long output hold while pixels keep coming, so the pipeline backs up
        load_ground_setting();
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        want_backlog = 1'b1;
        send_random(150);
        drain_results();

        // Spare register slots take writes without effect
        cfg_write(REG_HOLE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_HOLE_HI, {$urandom, $urandom});

        for (int k = 0; k < 6; k++) begin
            if (k % 3 == 2)
                load_wild_setting();
            else
                load_ground_setting();
            run_phase(120);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d pixels over %0d register settings: %0d valid, %0d on the plane,",
                 n_pixels, n_settings + 1, n_valid, n_trav);
        $display("%0d with a saturated coordinate; input held off for %0d cycles; %0d mismatches.",
                 n_sat, n_in_stall, n_fail);
        if (n_fail == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dpgpc_pkg.sv
rtl/core/dpgpc_cfg_regs.sv
rtl/core/dpgpc_pipe_ctrl.sv
rtl/core/dpgpc_backproject.sv
rtl/core/dpgpc_plane_test.sv
rtl/core/depth_pixel_ground_plane_classifier.sv
dv/tb_depth_pixel_ground_plane_classifier.sv
